// File: rtl/primitive_key_sort_and_hash_top_macros.svh
// Assertion macros for the primitive key sort and hash RTL.
// Depends on nothing; included by the top level, the only module that asserts.
`ifndef PRIMITIVE_KEY_SORT_AND_HASH_TOP_MACROS_SVH
`define PRIMITIVE_KEY_SORT_AND_HASH_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PKSH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PKSH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/pksh_pkg.sv
// Package for the primitive key sort and hash block: word types,
// constants and the IEEE ordering helper. Depends on nothing.
`default_nettype none
package pksh_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [3:0]  NCOORD_SEG = 4'd4;
  localparam logic [3:0]  NCOORD_TRI = 4'd9;
  localparam int unsigned NCELLS = 9;

  typedef struct packed {
    logic        func;
    logic [63:0] v0_x;
    logic [63:0] v0_y;
    logic [63:0] v0_z;
    logic [63:0] v1_x;
    logic [63:0] v1_y;
    logic [63:0] v1_z;
    logic [63:0] v2_x;
    logic [63:0] v2_y;
    logic [63:0] v2_z;
  } in_word_t;

  typedef struct packed {
    logic [63:0] key_hash;
    logic [3:0]  coord_count;
    logic [2:0]  sorted_order;
  } out_word_t;

  // Work carried along the hash chain: nine sorted coordinates (unused
  // ones are skipped through the count), the running hash and side data.
  typedef struct packed {
    logic [8:0][63:0] coord;
    logic [3:0]       count;
    logic [2:0]       order;
    logic [63:0]      hash;
  } hash_job_t;

  function automatic logic is_nan(input logic [63:0] a);
    is_nan = (a[62:0] > 63'h7ff0000000000000);
  endfunction

  function automatic logic flt_lt(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = a[63] ? ~a : (a | 64'h8000000000000000);
    kb = b[63] ? ~b : (b | 64'h8000000000000000);
    if (is_nan(a) || is_nan(b)) flt_lt = 1'b0;
    else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) flt_lt = 1'b0;
    else flt_lt = (ka < kb);
  endfunction

endpackage
`default_nettype wire

// File: rtl/pksh_sort.sv
// Sorting front end: vertex compare network with registered stages.
// Depends on pksh_pkg.
`default_nettype none
module pksh_sort
  import pksh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  wire in_word_t  in_word,
  output logic           out_vld,
  output hash_job_t      out_job
);

  typedef logic [2:0][63:0] vtx_t;

  function automatic logic vgt(input vtx_t a, input vtx_t b, input logic is_tri);
    logic r;
    r = 1'b0;
    if (flt_lt(b[0], a[0])) r = 1'b1;
    else if (!flt_lt(a[0], b[0])) begin
      if (flt_lt(b[1], a[1])) r = 1'b1;
      else if (!flt_lt(a[1], b[1]) && is_tri) r = flt_lt(b[2], a[2]);
    end
    vgt = r;
  endfunction

  // Stage 1 compares every ordered pair of the raw input vertices; the swap
  // decisions of the network follow from these compares alone.
  logic        s1_vld_r;
  logic        s1_tri_r;
  vtx_t [2:0]  s1_v_r;
  logic        s1_g01_r, s1_g12_r, s1_g02_r;
  vtx_t        va, vb, vc;

  always_comb begin
    va = {in_word.v0_z, in_word.v0_y, in_word.v0_x};
    vb = {in_word.v1_z, in_word.v1_y, in_word.v1_x};
    vc = {in_word.v2_z, in_word.v2_y, in_word.v2_x};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
    if (en) begin
      s1_tri_r <= in_word.func;
      s1_v_r   <= {vc, vb, va};
      s1_g01_r <= vgt(va, vb, in_word.func);
      s1_g12_r <= vgt(vb, vc, in_word.func);
      s1_g02_r <= vgt(va, vc, in_word.func);
    end
  end

  // Stage 2: replay the bubble network on indices using the compare bits.
  logic [1:0] p0, p1, p2, t;
  hash_job_t  job;

  // Reverse-order compares: vgt(b,a) is not simply !vgt(a,b) with NaNs or
  // equal keys, so they are computed in stage 1 as well.
  logic s1_g10_r, s1_g21_r, s1_g20_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_g10_r <= vgt(vb, va, in_word.func);
      s1_g21_r <= vgt(vc, vb, in_word.func);
      s1_g20_r <= vgt(vc, va, in_word.func);
    end
  end

  function automatic logic gpair(input logic [1:0] i, input logic [1:0] j,
                                 input logic [5:0] g);
    logic r;
    case ({i, j})
      4'b0001: r = g[0];
      4'b0100: r = g[1];
      4'b0110: r = g[2];
      4'b1001: r = g[3];
      4'b0010: r = g[4];
      4'b1000: r = g[5];
      default: r = 1'b0;
    endcase
    gpair = r;
  endfunction

  logic [5:0] gv;
  always_comb begin
    gv = {s1_g20_r, s1_g02_r, s1_g21_r, s1_g12_r, s1_g10_r, s1_g01_r};
    p0 = 2'd0; p1 = 2'd1; p2 = 2'd2;
    if (gpair(p0, p1, gv)) begin t = p0; p0 = p1; p1 = t; end
    else t = p0;
    if (s1_tri_r) begin
      if (gpair(p1, p2, gv)) begin t = p1; p1 = p2; p2 = t; end
      if (gpair(p0, p1, gv)) begin t = p0; p0 = p1; p1 = t; end
    end
    job.coord[0] = s1_v_r[p0][0];
    job.coord[1] = s1_v_r[p0][1];
    if (s1_tri_r) begin
      job.coord[2] = s1_v_r[p0][2];
      job.coord[3] = s1_v_r[p1][0];
      job.coord[4] = s1_v_r[p1][1];
      job.coord[5] = s1_v_r[p1][2];
      job.coord[6] = s1_v_r[p2][0];
      job.coord[7] = s1_v_r[p2][1];
      job.coord[8] = s1_v_r[p2][2];
      job.count    = NCOORD_TRI;
      job.order    = {p0, 1'b0} + {2'b00, (p1 > p2)};
    end else begin
      job.coord[2] = s1_v_r[p1][0];
      job.coord[3] = s1_v_r[p1][1];
      job.coord[4] = 64'd0;
      job.coord[5] = 64'd0;
      job.coord[6] = 64'd0;
      job.coord[7] = 64'd0;
      job.coord[8] = 64'd0;
      job.count    = NCOORD_SEG;
      job.order    = {1'b0, p0};
    end
    job.hash = FNV_BASIS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= s1_vld_r;
    end
    if (en) out_job <= job;
  end

endmodule
`default_nettype wire

// File: rtl/pksh_cell.sv
// One hash cell: folds one byte into the FNV-1a state per cell stage when
// its coordinate is within the count, registered. Depends on pksh_pkg.
`default_nettype none
module pksh_cell
  import pksh_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_vld,
  input  wire hash_job_t in_job,
  output logic           out_vld,
  output hash_job_t      out_job
);

  localparam int unsigned CRD = IDX / 8;
  localparam int unsigned BYT = IDX % 8;

  hash_job_t job_nxt;
  logic [7:0] byte_v;
  logic [63:0] mix;

  // The prime 2^40 + 0x1b3 is sparse, so the product is a short sum of shifts.
  always_comb begin
    job_nxt = in_job;
    byte_v  = in_job.coord[CRD][BYT*8 +: 8];
    mix     = in_job.hash ^ {56'd0, byte_v};
    if (CRD < 32'(in_job.count)) begin
      job_nxt.hash = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5)
                   + (mix << 4) + (mix << 1) + mix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) out_job <= job_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/primitive_key_sort_and_hash_top.sv
// Top level of the primitive key sort and hash block.
// Depends on pksh_pkg, pksh_sort, pksh_cell and the macros header.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_ready  | in_word_t
//   out_    | output    | out_valid / out_ready| out_word_t
//
// A word is accepted every cycle unless the pipeline stalls. The path is
// two sort stages, then a chain of 72 hash cells, one byte per cell, since
// each byte step is a 64-bit multiply by the sparse FNV prime. An output
// register follows.
// Reset (rst_n low, synchronous) empties the pipeline.
// The whole pipeline advances together; it stalls only when the output
// register is full and not being taken.
`default_nettype none
`include "primitive_key_sort_and_hash_top_macros.svh"
module primitive_key_sort_and_hash_top
  import pksh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int unsigned NB = NCELLS * 8;

  logic en;
  logic out_valid_r;
  out_word_t out_word_r;

  // The chain moves when the output slot is free or being emptied.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic      vld [0:NB];
  hash_job_t job [0:NB];

  pksh_sort u_sort (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_valid), .in_word(in_word),
    .out_vld(vld[0]), .out_job(job[0])
  );

  for (genvar i = 0; i < NB; i++) begin : g_cell
    pksh_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(vld[i]), .in_job(job[i]),
      .out_vld(vld[i+1]), .out_job(job[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[NB];
    end
    if (en) begin
      out_word_r.key_hash     <= job[NB].hash;
      out_word_r.coord_count  <= job[NB].count;
      out_word_r.sorted_order <= job[NB].order;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PKSH_ASSERT_NXT(a_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_word_r))
  `PKSH_ASSERT_IMP(a_cnt, out_valid_r,
    out_word_r.coord_count == NCOORD_SEG || out_word_r.coord_count == NCOORD_TRI)
  `PKSH_ASSERT_IMP(a_seg_ord, out_valid_r && out_word_r.coord_count == NCOORD_SEG,
    out_word_r.sorted_order < 3'd2)
  `PKSH_ASSERT_IMP(a_ord, out_valid_r, out_word_r.sorted_order < 3'd6)

endmodule
`default_nettype wire
